/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

/* design/dte_pkg.sv */
// ---------------------------------------------------------------------------
// Detector trigger emulator package
// Field widths, channel map, register indexes, reset values and states.
// ---------------------------------------------------------------------------
`default_nettype none

package dte_pkg;

  localparam int SIDE_A_CHANNELS = 96;
  localparam int SIDE_C_CHANNELS = 112;

  localparam int CH_W    = 8;
  localparam int AMP_W   = 13;
  localparam int TIME_W  = 12;
  localparam int REF_W   = 8;
  localparam int TRIG_W  = 5;
  localparam int CNT_W   = 8;
  localparam int ASUM_W  = 21;
  localparam int TSUM_W  = 20;
  localparam int THR_W   = 20;
  localparam int VWIN_W  = 12;
  localparam int REM_W   = CNT_W;
  localparam int STEP_W  = 5;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 104;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CH_W:0] SIDE_A_END = (CH_W + 1)'(SIDE_A_CHANNELS);
  localparam logic [CH_W:0] SIDE_C_END = (CH_W + 1)'(SIDE_A_CHANNELS + SIDE_C_CHANNELS);
  localparam logic [CNT_W-1:0] CNT_FULL = '1;
  localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(TSUM_W - 1);

  localparam logic [CFG_ADDR_W-1:0] CFG_SIDE_MODE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_THR_VARIABLE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_VTX_LOW      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_VTX_HIGH     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_CEN_A        = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_CEN_C        = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCEN_A       = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCEN_C       = 3'd7;

  typedef enum logic [1:0] {
    MODE_SUM  = 2'd0,
    MODE_BOTH = 2'd1,
    MODE_A    = 2'd2,
    MODE_C    = 2'd3
  } side_mode_t;

  localparam logic signed [VWIN_W-1:0] VTX_LOW_RST  = -12'sd192;
  localparam logic signed [VWIN_W-1:0] VTX_HIGH_RST = 12'sd192;
  localparam logic [THR_W-1:0] CEN_RST  = 20'd600;
  localparam logic [THR_W-1:0] SCEN_RST = 20'd300;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_LDA,
    S_DIVA,
    S_LDC,
    S_DIVC,
    S_VTX,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

/* design/detector_trigger_emulator.sv */
// ---------------------------------------------------------------------------
// Detector trigger emulator
// Sums channel hits per side over a bunch crossing and checks trigger bits.
// ---------------------------------------------------------------------------
// Input stream: one hit per request; tuser is the hit flag (0 = empty item),
// tlast closes the bunch crossing. Output stream: one request per closed
// crossing with the emulated trigger bits, the mismatch mask against the
// reference word, counts, amplitude sums, mean times and vertex.
// Config channel: register writes by index, always ready; write only while
// the block is idle.
// Steps: an item that does not close a crossing is accepted, then
// accumulated. A closing item is accepted and accumulated, then side A
// and side C are each loaded into one shared restoring divider that
// resolves one quotient bit per cycle, then the vertex and output steps
// fill the output register with the mean times and vertex.
// Reset clears the sums, the output valid flag and the config registers to
// their defaults. If the receiver stalls, the result holds in the output
// register; the next crossing is still taken in, and it waits at its final
// step until the previous result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module detector_trigger_emulator
  import dte_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // cfg
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // in: channel_id, amplitude, hit_time, reference_triggers, zero pad
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tlast,
  // in_tuser: hit_valid
  input  wire logic                  in_tuser,
  // out: soft_triggers, mismatch_mask, fired_count_a, fired_count_c,
  //      amplitude_sum_a, amplitude_sum_c, mean_time_a, mean_time_c,
  //      vertex_position
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  state_t state_r, state_nxt;

  side_mode_t                 side_mode_r;
  logic                       thr_var_r;
  logic signed [VWIN_W-1:0]   vtx_low_r, vtx_high_r;
  logic [THR_W-1:0]           cen_a_r, cen_c_r, scen_a_r, scen_c_r;

  logic                       hit_r, last_r;
  logic [CH_W-1:0]            ch_r;
  logic signed [AMP_W-1:0]    amp_r;
  logic signed [TIME_W-1:0]   time_r;
  logic [TRIG_W-1:0]          ref_r;

  logic signed [ASUM_W-1:0]   amp_a_r, amp_c_r;
  logic signed [TSUM_W-1:0]   tsum_a_r, tsum_c_r;
  logic [CNT_W-1:0]           hits_a_r, hits_c_r;

  logic [TSUM_W-1:0]          div_q_r;
  logic [REM_W-1:0]           div_rem_r;
  logic [CNT_W-1:0]           div_den_r;
  logic                       div_neg_r;
  logic [STEP_W-1:0]          div_cnt_r;

  logic signed [TIME_W-1:0]   mean_a_r, mean_c_r, vtx_r;

  logic                       out_tvalid_r;
  logic [OUT_DATA_W-1:0]      out_tdata_r;

  // control
  logic in_take, acc_en, div_step, div_done, out_load;

  // datapath nets
  logic                       side_a, side_c;
  logic [REM_W:0]             rem_sh;
  logic                       q_bit;
  logic [TSUM_W-1:0]          q_next, q_signed;
  logic signed [TIME_W-1:0]   div_mean;
  logic [TSUM_W-1:0]          abs_a, abs_c;
  logic signed [TIME_W:0]     vdiff, vdiff_rnd;
  logic signed [ASUM_W:0]     va, vc;
  logic signed [ASUM_W+1:0]   vsum, thr_cen_a, thr_cen_c, thr_scen_a, thr_scen_c;
  logic signed [ASUM_W+1:0]   va_x, vc_x;
  logic                       cen, scen, vtx_in;
  logic [TRIG_W-1:0]          trig_bits;

  // ---------------------------------------------------------------- fsm
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_ACC;
      S_ACC:  state_nxt = last_r ? S_LDA : S_IDLE;
      S_LDA:  state_nxt = S_DIVA;
      S_DIVA: if (div_cnt_r == DIV_LAST_STEP) state_nxt = S_LDC;
      S_LDC:  state_nxt = S_DIVC;
      S_DIVC: if (div_cnt_r == DIV_LAST_STEP) state_nxt = S_VTX;
      S_VTX:  state_nxt = S_OUT;
      S_OUT:  if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    acc_en    = 1'b0;
    div_step  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE:         in_tready = 1'b1;
      S_ACC:          acc_en    = 1'b1;
      S_DIVA, S_DIVC: div_step  = 1'b1;
      S_OUT:          out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  assign in_take  = in_tvalid && in_tready;
  assign div_done = div_step && (div_cnt_r == DIV_LAST_STEP);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_mode_r <= MODE_SUM;
      thr_var_r   <= 1'b0;
      vtx_low_r   <= VTX_LOW_RST;
      vtx_high_r  <= VTX_HIGH_RST;
      cen_a_r     <= CEN_RST;
      cen_c_r     <= CEN_RST;
      scen_a_r    <= SCEN_RST;
      scen_c_r    <= SCEN_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_SIDE_MODE:    side_mode_r <= side_mode_t'(cfg_data[1:0]);
        CFG_THR_VARIABLE: thr_var_r   <= cfg_data[0];
        CFG_VTX_LOW:      vtx_low_r   <= cfg_data[VWIN_W-1:0];
        CFG_VTX_HIGH:     vtx_high_r  <= cfg_data[VWIN_W-1:0];
        CFG_CEN_A:        cen_a_r     <= cfg_data;
        CFG_CEN_C:        cen_c_r     <= cfg_data;
        CFG_SCEN_A:       scen_a_r    <= cfg_data;
        CFG_SCEN_C:       scen_c_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
      hit_r  <= 1'b0;
    end else if (in_take) begin
      last_r <= in_tlast;
      hit_r  <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r   <= in_tdata[7:0];
      amp_r  <= in_tdata[20:8];
      time_r <= in_tdata[32:21];
      ref_r  <= in_tdata[37:33];
    end
  end

  // ---------------------------------------------------------------- sums
  assign side_a = ({1'b0, ch_r} < SIDE_A_END) && (hits_a_r != CNT_FULL);
  assign side_c = ({1'b0, ch_r} >= SIDE_A_END) && ({1'b0, ch_r} < SIDE_C_END) &&
                  (hits_c_r != CNT_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n || out_load) begin
      amp_a_r  <= '0;
      amp_c_r  <= '0;
      tsum_a_r <= '0;
      tsum_c_r <= '0;
      hits_a_r <= '0;
      hits_c_r <= '0;
    end else if (acc_en && hit_r) begin
      if (side_a) begin
        amp_a_r  <= amp_a_r + ASUM_W'(amp_r);
        tsum_a_r <= tsum_a_r + TSUM_W'(time_r);
        hits_a_r <= hits_a_r + 1'b1;
      end
      if (side_c) begin
        amp_c_r  <= amp_c_r + ASUM_W'(amp_r);
        tsum_c_r <= tsum_c_r + TSUM_W'(time_r);
        hits_c_r <= hits_c_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- divider
  assign abs_a = tsum_a_r[TSUM_W-1] ? -tsum_a_r : tsum_a_r;
  assign abs_c = tsum_c_r[TSUM_W-1] ? -tsum_c_r : tsum_c_r;

  assign rem_sh   = {div_rem_r, div_q_r[TSUM_W-1]};
  assign q_bit    = rem_sh >= {1'b0, div_den_r};
  assign q_next   = {div_q_r[TSUM_W-2:0], q_bit};
  assign q_signed = div_neg_r ? -q_next : q_next;
  assign div_mean = (div_den_r == '0) ? '0 : q_signed[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (state_r == S_LDA || state_r == S_LDC) begin
      div_cnt_r <= '0;
    end else if (div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LDA) begin
      div_q_r   <= abs_a;
      div_neg_r <= tsum_a_r[TSUM_W-1];
      div_den_r <= hits_a_r;
      div_rem_r <= '0;
    end else if (state_r == S_LDC) begin
      div_q_r   <= abs_c;
      div_neg_r <= tsum_c_r[TSUM_W-1];
      div_den_r <= hits_c_r;
      div_rem_r <= '0;
    end else if (div_step) begin
      div_q_r   <= q_next;
      div_rem_r <= q_bit ? REM_W'(rem_sh - {1'b0, div_den_r}) : rem_sh[REM_W-1:0];
    end
    if (div_done && state_r == S_DIVA) mean_a_r <= div_mean;
    if (div_done && state_r == S_DIVC) mean_c_r <= div_mean;
  end

  // ---------------------------------------------------------------- vertex
  assign vdiff     = {mean_c_r[TIME_W-1], mean_c_r} - {mean_a_r[TIME_W-1], mean_a_r};
  assign vdiff_rnd = vdiff + {{TIME_W{1'b0}}, vdiff[TIME_W]};

  always_ff @(posedge clk) begin
    if (state_r == S_VTX) begin
      vtx_r <= (hits_a_r != '0 && hits_c_r != '0) ? vdiff_rnd[TIME_W:1] : '0;
    end
  end

  // ---------------------------------------------------------------- triggers
  assign va = thr_var_r ? {{(ASUM_W-CNT_W+1){1'b0}}, hits_a_r} : {amp_a_r[ASUM_W-1], amp_a_r};
  assign vc = thr_var_r ? {{(ASUM_W-CNT_W+1){1'b0}}, hits_c_r} : {amp_c_r[ASUM_W-1], amp_c_r};
  assign va_x = {va[ASUM_W], va};
  assign vc_x = {vc[ASUM_W], vc};
  assign vsum = va_x + vc_x;

  assign thr_cen_a  = {3'b000, cen_a_r};
  assign thr_cen_c  = {3'b000, cen_c_r};
  assign thr_scen_a = {3'b000, scen_a_r};
  assign thr_scen_c = {3'b000, scen_c_r};

  always_comb begin
    case (side_mode_r)
      MODE_SUM: begin
        cen  = vsum >= thr_cen_a;
        scen = vsum >= thr_scen_a;
      end
      MODE_BOTH: begin
        cen  = (va_x >= thr_cen_a) && (vc_x >= thr_cen_c);
        scen = (va_x >= thr_scen_a) && (vc_x >= thr_scen_c);
      end
      MODE_A: begin
        cen  = va_x >= thr_cen_a;
        scen = va_x >= thr_scen_a;
      end
      default: begin
        cen  = vc_x >= thr_cen_c;
        scen = vc_x >= thr_scen_c;
      end
    endcase
  end

  assign vtx_in    = (hits_a_r != '0) && (hits_c_r != '0) &&
                     (vtx_low_r < vtx_r) && (vtx_r < vtx_high_r);
  assign trig_bits = {scen, cen, vtx_in, hits_c_r != '0, hits_a_r != '0};

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {vtx_r, mean_c_r, mean_a_r, amp_c_r, amp_a_r,
                      hits_c_r, hits_a_r, trig_bits ^ ref_r, trig_bits};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------------------------------------------------------- checks
  `ASSERT_CLK(a_out_from_eval, $rose(out_tvalid_r) |-> $past(state_r) == S_OUT,
    "result shown without evaluation")
  `ASSERT_CLK(a_div_rem, (div_step && div_den_r != '0) |-> div_rem_r < div_den_r,
    "divider remainder out of range")
  `ASSERT_CLK(a_clear_after_out, out_load |=> hits_a_r == '0 && hits_c_r == '0,
    "sums not cleared after result")

endmodule

`default_nettype wire
